// ===== hw/rtl/idpc_pkg.sv =====
// shared types, codes and defaults of the implant/decay pixel correlator
package idpc_pkg;
   localparam int DEF_GRID_ROWS = 40;
   localparam int DEF_GRID_COLS = 40;
   localparam int DEF_TIME_BITS = 48;

   localparam int POS_W = 6;
   localparam int CNT_W = 11;
   localparam int CSR_IDX_W = 2;

   typedef logic [1:0] op_type;
   typedef logic [2:0] status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam op_type OP_IMPLANT = 2'd0;
   localparam op_type OP_DECAY = 2'd1;
   localparam op_type OP_EXPIRE = 2'd2;

   localparam status_type ST_STORED = 3'd0;
   localparam status_type ST_FLUSHED = 3'd1;
   localparam status_type ST_BACK2BACK = 3'd2;
   localparam status_type ST_IGNORED = 3'd3;
   localparam status_type ST_MATCHED = 3'd4;
   localparam status_type ST_NO_MATCH = 3'd5;
   localparam status_type ST_EXPIRED = 3'd6;

   localparam csr_idx_type CSR_MIN_GAP = 2'd0;
   localparam csr_idx_type CSR_CORR_WIN = 2'd1;
   localparam csr_idx_type CSR_EXPIRE = 2'd2;
endpackage

// ===== hw/rtl/idpc_if.sv =====
// request and response channel interfaces
interface idpc_req_if #(parameter int TIME_BITS = idpc_pkg::DEF_TIME_BITS);
   logic valid;
   logic ready;
   idpc_pkg::op_type operation;
   idpc_pkg::pos_type row;
   idpc_pkg::pos_type col;
   logic [TIME_BITS-1:0] timestamp;
   modport source (output valid, operation, row, col, timestamp, input ready);
   modport sink (input valid, operation, row, col, timestamp, output ready);
endinterface

interface idpc_rsp_if #(parameter int TIME_BITS = idpc_pkg::DEF_TIME_BITS);
   logic valid;
   logic ready;
   idpc_pkg::status_type status;
   idpc_pkg::pos_type out_row;
   idpc_pkg::pos_type out_col;
   logic [TIME_BITS-1:0] time_value;
   idpc_pkg::cnt_type cleared_count;
   modport source (output valid, status, out_row, out_col, time_value, cleared_count,
                   input ready);
   modport sink (input valid, status, out_row, out_col, time_value, cleared_count,
                 output ready);
endinterface

// ===== hw/rtl/implant_decay_pixel_correlator.sv =====
// top level of the implant/decay pixel correlator
// The block keeps a GRID_ROWS x GRID_COLS pixel map in two memories, each with
// one read and one write port (occupied flag with implant time, and back-to-back
// gap) and runs one request transaction at a time under a small sequencer around
// one shared subtractor. After reset a clearing pass writes every pixel, during
// which no request is taken; csr writes are taken at any time. An implant reads
// its pixel and then evaluates it (it goes straight to the result when it is off
// the grid or the operation code is unused), a decay reads and evaluates each
// on-grid neighbour and skips each off-grid one, and an expire reads each pixel
// and checks its implant and then its gap, each step with at most one memory read
// and one shared subtract/compare. The result sits in an output register, so a
// new request is taken while the previous response still waits; the last step
// stalls only while that register is still full.
module implant_decay_pixel_correlator #(
   parameter int GRID_ROWS = idpc_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = idpc_pkg::DEF_GRID_COLS,
   parameter int TIME_BITS = idpc_pkg::DEF_TIME_BITS
) (
   input  logic clock,
   input  logic reset,
   idpc_req_if.sink req_if,
   idpc_rsp_if.source rsp_if,
   input  logic csr_we,
   input  idpc_pkg::csr_idx_type csr_index,
   input  logic [TIME_BITS-1:0] csr_data
);
   import idpc_pkg::*;

   localparam int NPIX = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(NPIX);
   localparam int TB = TIME_BITS;

   // sequencer states
   localparam logic [3:0] S_CLR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_IRD = 4'd2;
   localparam logic [3:0] S_IEV = 4'd3;
   localparam logic [3:0] S_DRD = 4'd4;
   localparam logic [3:0] S_DEV = 4'd5;
   localparam logic [3:0] S_DFIN = 4'd6;
   localparam logic [3:0] S_XRD = 4'd7;
   localparam logic [3:0] S_XEV1 = 4'd8;
   localparam logic [3:0] S_XEV2 = 4'd9;
   localparam logic [3:0] S_FIN = 4'd10;

   logic [3:0] state_ff, state_in;

   // csr registers
   logic [TB-1:0] min_gap_ff, corr_win_ff, expire_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff <= '0;
         corr_win_ff <= '0;
         expire_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_GAP: min_gap_ff <= csr_data;
            CSR_CORR_WIN: corr_win_ff <= csr_data;
            CSR_EXPIRE: expire_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // captured request
   op_type op_ff, op_in;
   pos_type row_ff, row_in, col_ff, col_in;
   logic [TB-1:0] t_ff, t_in;

   // sweep / pixel address and neighbour counters
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [1:0] dr_ff, dr_in, dc_ff, dc_in;

   // best decay candidate
   logic found_ff, found_in;
   logic [TB-1:0] best_dt_ff, best_dt_in, bgap_ff, bgap_in;
   pos_type br_ff, br_in, bc_ff, bc_in;

   // pending result and response register
   status_type res_st_ff, res_st_in;
   pos_type res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic [TB-1:0] res_t_ff, res_t_in;
   cnt_type cnt_ff, cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_st_ff, rsp_st_in;
   pos_type rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [TB-1:0] rsp_t_ff, rsp_t_in;
   cnt_type rsp_cnt_ff, rsp_cnt_in;

   // memories: {occupied, implant time} and gap
   logic [TB:0] time_mem_ff [NPIX];
   logic [TB-1:0] gap_mem_ff [NPIX];
   logic [TB:0] tm_rd_ff;
   logic [TB-1:0] gap_rd_ff;
   logic rd_en, tm_we, gap_we;
   logic [ADDR_W-1:0] rd_addr;
   logic [TB:0] tm_wd;
   logic [TB-1:0] gap_wd;

   always_ff @(posedge clock) begin
      if (tm_we) time_mem_ff[addr_ff] <= tm_wd;
      if (rd_en) tm_rd_ff <= time_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (gap_we) gap_mem_ff[addr_ff] <= gap_wd;
      if (rd_en) gap_rd_ff <= gap_mem_ff[rd_addr];
   end

   // neighbour coordinates of the decay search
   logic signed [7:0] nr_s, nc_s;
   logic nb_ok;
   pos_type nb_r, nb_c;
   logic [ADDR_W-1:0] nb_addr;

   always_comb begin
      nr_s = $signed({2'b00, row_ff}) + $signed({6'b0, dr_ff}) - 8'sd1;
      nc_s = $signed({2'b00, col_ff}) + $signed({6'b0, dc_ff}) - 8'sd1;
      nb_ok = (nr_s >= 0) && (int'(nr_s) < GRID_ROWS) && (nc_s >= 0) &&
              (int'(nc_s) < GRID_COLS);
      nb_r = nr_s[POS_W-1:0];
      nb_c = nc_s[POS_W-1:0];
      nb_addr = ADDR_W'(int'(nb_r) * GRID_COLS + int'(nb_c));
   end

   // shared subtract / compare unit: t minus a stored time or gap
   logic [TB-1:0] op_b, dif, absd;
   logic [TB:0] diff_full;
   logic borrow, later, exceed;
   logic occ;

   always_comb begin
      occ = tm_rd_ff[TB];
      op_b = (state_ff == S_XEV2) ? gap_rd_ff : tm_rd_ff[TB-1:0];
      diff_full = {1'b0, t_ff} - {1'b0, op_b};
      borrow = diff_full[TB];
      dif = diff_full[TB-1:0];
      later = !borrow && (dif != '0);
      absd = borrow ? (~dif + 1'b1) : dif;
      exceed = absd > expire_ff;
   end

   logic req_acc, grid_in;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_acc = req_if.valid && req_if.ready;
   assign grid_in = (int'(req_if.row) < GRID_ROWS) && (int'(req_if.col) < GRID_COLS);

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = rsp_st_ff;
   assign rsp_if.out_row = rsp_row_ff;
   assign rsp_if.out_col = rsp_col_ff;
   assign rsp_if.time_value = rsp_t_ff;
   assign rsp_if.cleared_count = rsp_cnt_ff;

   // neighbour step: next column, then next row, then done
   logic nb_last;
   assign nb_last = (dr_ff == 2'd2) && (dc_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      row_in = row_ff;
      col_in = col_ff;
      t_in = t_ff;
      addr_in = addr_ff;
      dr_in = dr_ff;
      dc_in = dc_ff;
      found_in = found_ff;
      best_dt_in = best_dt_ff;
      bgap_in = bgap_ff;
      br_in = br_ff;
      bc_in = bc_ff;
      res_st_in = res_st_ff;
      res_row_in = res_row_ff;
      res_col_in = res_col_ff;
      res_t_in = res_t_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_st_in = rsp_st_ff;
      rsp_row_in = rsp_row_ff;
      rsp_col_in = rsp_col_ff;
      rsp_t_in = rsp_t_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rd_en = 1'b0;
      rd_addr = addr_ff;
      tm_we = 1'b0;
      gap_we = 1'b0;
      tm_wd = {1'b0, tm_rd_ff[TB-1:0]};
      gap_wd = '0;

      case (state_ff)
         S_CLR: begin
            // clearing pass: empty every pixel, zero every gap
            tm_we = 1'b1;
            tm_wd = '0;
            gap_we = 1'b1;
            if (int'(addr_ff) == NPIX - 1) begin
               addr_in = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               op_in = req_if.operation;
               row_in = req_if.row;
               col_in = req_if.col;
               t_in = req_if.timestamp;
               res_st_in = ST_IGNORED;
               res_row_in = '0;
               res_col_in = '0;
               res_t_in = '0;
               cnt_in = '0;
               found_in = 1'b0;
               best_dt_in = '0;
               dr_in = '0;
               dc_in = '0;
               addr_in = '0;
               case (req_if.operation)
                  OP_IMPLANT: begin
                     if (grid_in) begin
                        addr_in = ADDR_W'(int'(req_if.row) * GRID_COLS + int'(req_if.col));
                        state_in = S_IRD;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  OP_DECAY: state_in = S_DRD;
                  OP_EXPIRE: state_in = S_XRD;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_IRD: begin
            rd_en = 1'b1;
            state_in = S_IEV;
         end
         S_IEV: begin
            res_row_in = row_ff;
            res_col_in = col_ff;
            if (!occ) begin
               tm_we = 1'b1;
               tm_wd = {1'b1, t_ff};
               res_st_in = ST_STORED;
            end else if (later) begin
               gap_we = 1'b1;
               gap_wd = dif;
               if (dif > min_gap_ff) begin
                  // flush: pixel left empty, new implant not stored
                  tm_we = 1'b1;
                  tm_wd = {1'b0, tm_rd_ff[TB-1:0]};
                  res_st_in = ST_FLUSHED;
                  res_t_in = tm_rd_ff[TB-1:0];
               end else begin
                  res_st_in = ST_BACK2BACK;
                  res_t_in = dif;
               end
            end else begin
               res_st_in = ST_IGNORED;
            end
            state_in = S_FIN;
         end
         S_DRD: begin
            if (nb_ok) begin
               rd_en = 1'b1;
               rd_addr = nb_addr;
               state_in = S_DEV;
            end else if (nb_last) begin
               state_in = S_DFIN;
            end else if (dc_ff == 2'd2) begin
               dc_in = '0;
               dr_in = dr_ff + 1'b1;
            end else begin
               dc_in = dc_ff + 1'b1;
            end
         end
         S_DEV: begin
            // strict less keeps the first candidate in row-major order on ties
            if (occ && later && (!found_ff || (dif < best_dt_ff))) begin
               found_in = 1'b1;
               best_dt_in = dif;
               br_in = nb_r;
               bc_in = nb_c;
               bgap_in = gap_rd_ff;
            end
            if (nb_last) begin
               state_in = S_DFIN;
            end else begin
               state_in = S_DRD;
               if (dc_ff == 2'd2) begin
                  dc_in = '0;
                  dr_in = dr_ff + 1'b1;
               end else begin
                  dc_in = dc_ff + 1'b1;
               end
            end
         end
         S_DFIN: begin
            if (found_ff && !(best_dt_ff > corr_win_ff) &&
                !((bgap_ff != '0) && (bgap_ff < min_gap_ff))) begin
               res_st_in = ST_MATCHED;
               res_row_in = br_ff;
               res_col_in = bc_ff;
               res_t_in = best_dt_ff;
            end else begin
               res_st_in = ST_NO_MATCH;
            end
            state_in = S_FIN;
         end
         S_XRD: begin
            rd_en = 1'b1;
            state_in = S_XEV1;
         end
         S_XEV1: begin
            // stale implant: empty the pixel and count it
            if (occ && exceed) begin
               tm_we = 1'b1;
               tm_wd = {1'b0, tm_rd_ff[TB-1:0]};
               if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
            end
            state_in = S_XEV2;
         end
         S_XEV2: begin
            // stale gap: clear to none
            if ((gap_rd_ff != '0) && exceed) begin
               gap_we = 1'b1;
               gap_wd = '0;
            end
            if (int'(addr_ff) == NPIX - 1) begin
               res_st_in = ST_EXPIRED;
               state_in = S_FIN;
            end else begin
               addr_in = addr_ff + 1'b1;
               state_in = S_XRD;
            end
         end
         S_FIN: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in = res_st_ff;
               rsp_row_in = res_row_ff;
               rsp_col_in = res_col_ff;
               rsp_t_in = res_t_ff;
               rsp_cnt_in = (op_ff == OP_EXPIRE) ? cnt_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      row_ff <= row_in;
      col_ff <= col_in;
      t_ff <= t_in;
      dr_ff <= dr_in;
      dc_ff <= dc_in;
      best_dt_ff <= best_dt_in;
      bgap_ff <= bgap_in;
      br_ff <= br_in;
      bc_ff <= bc_in;
      res_st_ff <= res_st_in;
      res_row_ff <= res_row_in;
      res_col_ff <= res_col_in;
      res_t_ff <= res_t_in;
      cnt_ff <= cnt_in;
      rsp_st_ff <= rsp_st_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_t_ff <= rsp_t_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end
endmodule

// ===== hw/rtl/idpc_checker.sv =====
// port-level assertions of the pixel correlator and their bind
module idpc_checker #(
   parameter int GRID_ROWS = idpc_pkg::DEF_GRID_ROWS
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input idpc_pkg::status_type rsp_status,
   input idpc_pkg::pos_type rsp_out_row,
   input idpc_pkg::cnt_type rsp_cleared_count
);
   import idpc_pkg::*;

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");

   a_count_only_expire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_EXPIRED)) |-> (rsp_cleared_count == '0))
      else $error("cleared count outside expire");

   a_row_on_grid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_MATCHED)) |-> (int'(rsp_out_row) < GRID_ROWS))
      else $error("matched row off the grid");
endmodule

bind implant_decay_pixel_correlator idpc_checker #(.GRID_ROWS(GRID_ROWS)) u_idpc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_status(rsp_if.status),
   .rsp_out_row(rsp_if.out_row),
   .rsp_cleared_count(rsp_if.cleared_count)
);
